// ===== rtl/prs_pkg.sv =====
package prs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned ERR_W = 47;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned SWP_W = 16;
  localparam int unsigned NCH = 3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // sequencer phase for one entry access
  typedef enum logic [3:0] {
    PH_NBR = 4'd0,  // read neighbor row and rhs / own x
    PH_NA  = 4'd1,
    PH_NB  = 4'd2,
    PH_NC  = 4'd3,
    PH_ND  = 4'd4,
    PH_ACC = 4'd5   // all neighbor values in, update or residual
  } phase_t;

  typedef struct packed {
    logic            load;
    logic            read;
    logic            clr_err;
    logic            clr_chg;
    logic            rd_row;
    logic [2:0]      rd_nbr;   // which neighbor (0..3) to fetch, bit 2 valid
    logic            capture;  // latch neighbor value from last fetch
    logic            update;   // write new x for current entry
    logic            resid;    // accumulate residual for current entry
    logic [IDX_W-1:0] entry;
  } cmd_t;

  typedef struct packed {
    logic changed;
  } sts_t;

endpackage

// ===== rtl/prs_ram.sv =====
module prs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/prs_datapath.sv =====
module prs_datapath #(
  parameter int unsigned MAX_ENTRIES = 4096,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  prs_pkg::cmd_t                          cmd,
  input  logic [4*prs_pkg::IDX_W-1:0]            ld_nbr,
  input  logic [prs_pkg::NCH*prs_pkg::DATA_W-1:0] ld_rhs,
  input  logic [prs_pkg::NCH*prs_pkg::DATA_W-1:0] ld_init,
  output prs_pkg::sts_t                          sts,
  output logic [prs_pkg::NCH*8-1:0]              pix,
  output logic [prs_pkg::NCH*prs_pkg::ERR_W-1:0] err
);
  import prs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned SW = DATA_W + 4;
  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  logic [4*IDX_W-1:0] nrow;
  logic [AW-1:0] nb_addr;
  logic          nb_oob, nb_oob_q;
  logic [AW-1:0] own;
  logic          sol_we;
  logic [AW-1:0] sol_waddr;
  logic [AW-1:0] sol_raddr;
  logic [DATA_W-1:0] rhs_q [NCH];
  logic [DATA_W-1:0] sol_q [NCH];
  logic [DATA_W-1:0] x_own [NCH];
  logic signed [SW-1:0] nsum [NCH];
  logic [DATA_W-1:0] sol_wd [NCH];
  logic [DATA_W-1:0] qsat [NCH];
  logic [ERR_W-1:0]  acc [NCH];
  logic              changed;
  logic [IDX_W-1:0]  nidx;
  logic [1:0]        nsel;

  assign own  = AW'(cmd.entry);
  assign nsel = cmd.rd_nbr[1:0];
  assign nidx = nrow[nsel*IDX_W +: IDX_W];
  assign nb_oob  = (32'(nidx) >= MAX_ENTRIES);
  assign nb_addr = AW'(nidx);

  assign sol_we    = cmd.load | cmd.update;
  assign sol_waddr = own;
  assign sol_raddr = cmd.rd_nbr[2] ? nb_addr : own;

  prs_ram #(.WIDTH(4*IDX_W), .DEPTH(MAX_ENTRIES)) u_nbr (
    .clk, .we(cmd.load), .waddr(own), .wdata(ld_nbr), .raddr(own), .rdata(nrow)
  );

  always_ff @(posedge clk) nb_oob_q <= cmd.rd_nbr[2] & nb_oob;

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] q;
    logic signed [SW+2:0] r;
    logic [SW+2:0]        m;
    logic [ERR_W:0]       asum;

    assign sol_wd[c] = cmd.load ? ld_init[c*DATA_W +: DATA_W] : qsat[c];

    prs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_rhs (
      .clk, .we(cmd.load), .waddr(own), .wdata(ld_rhs[c*DATA_W +: DATA_W]),
      .raddr(own), .rdata(rhs_q[c])
    );
    prs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_sol (
      .clk, .we(sol_we), .waddr(sol_waddr), .wdata(sol_wd[c]),
      .raddr(sol_raddr), .rdata(sol_q[c])
    );

    // floor quarter with saturation to 32 bits
    assign s = nsum[c] + SW'(signed'(rhs_q[c]));
    assign q = s >>> 2;
    always_comb begin
      if (q > SW'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
        qsat[c] = {1'b0, {(DATA_W-1){1'b1}}};
      else if (q < SW'(signed'({1'b1, {(DATA_W-1){1'b0}}})))
        qsat[c] = {1'b1, {(DATA_W-1){1'b0}}};
      else
        qsat[c] = q[DATA_W-1:0];
    end

    assign r = ((SW+3)'(signed'(x_own[c])) <<< 2) - (SW+3)'(nsum[c])
               - (SW+3)'(signed'(rhs_q[c]));
    assign m = r[SW+2] ? (SW+3)'(-r) : (SW+3)'(r);
    assign asum = (ERR_W+1)'(acc[c]) + (ERR_W+1)'(m);

    always_ff @(posedge clk) begin
      if (cmd.rd_row) begin
        nsum[c] <= '0;
      end else if (cmd.capture) begin
        nsum[c] <= nsum[c] + (nb_oob_q ? SW'(0) : SW'(signed'(sol_q[c])));
      end
      // own x arrives in the cycle after the row fetch
      if (cmd.rd_nbr == 3'b100 && !cmd.capture) x_own[c] <= sol_q[c];
      if (cmd.clr_err) acc[c] <= '0;
      else if (cmd.resid) acc[c] <= asum[ERR_W] ? ERR_MAX : asum[ERR_W-1:0];
      if (cmd.read) begin
        if (sol_q[c][DATA_W-1]) pix[c*8 +: 8] <= '0;
        else if (|(sol_q[c] >> (FRAC_BITS + 8))) pix[c*8 +: 8] <= 8'hff;
        else pix[c*8 +: 8] <= 8'(sol_q[c] >> FRAC_BITS);
      end
      err[c*ERR_W +: ERR_W] <= acc[c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_chg) changed <= 1'b0;
    else if (cmd.update && (qsat[0] != x_own[0] || qsat[1] != x_own[1]
                            || qsat[2] != x_own[2]))
      changed <= 1'b1;
  end

  assign sts.changed = changed;
endmodule

// ===== rtl/prs_ctrl.sv =====
module prs_ctrl #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  prs_pkg::op_t             op,
  input  logic [prs_pkg::IDX_W-1:0] idx,
  input  logic [prs_pkg::CNT_W-1:0] entry_count,
  input  logic [prs_pkg::SWP_W-1:0] sweep_count,
  input  prs_pkg::sts_t            sts,
  output prs_pkg::cmd_t            cmd,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_err,
  output logic [prs_pkg::IDX_W-1:0] out_idx,
  output logic                     oob_read
);
  import prs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_ENTRY = 6'b000100,
    S_SWEND = 6'b001000,
    S_ERR   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [2:0] step;        // 0 row, 1..4 neighbor fetch, 2..5 capture, 6 gap, 7 act
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] n;
  logic [SWP_W-1:0] sw;
  logic resid_mode;
  logic [CNT_W-1:0] ncap;

  assign ncap = (32'(entry_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : entry_count;
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.entry = i[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.entry = idx;
        if (in_valid && in_ready && op == OP_LOAD)
          cmd.load = (32'(idx) < MAX_ENTRIES);
      end
      S_READ: begin
        cmd.entry = out_idx;
        cmd.read = 1'b1;
      end
      S_ENTRY: begin
        unique case (step)
          3'd0: cmd.rd_row = 1'b1;
          3'd1: cmd.rd_nbr = 3'b100;
          3'd2: begin cmd.rd_nbr = 3'b101; cmd.capture = 1'b1; end
          3'd3: begin cmd.rd_nbr = 3'b110; cmd.capture = 1'b1; end
          3'd4: begin cmd.rd_nbr = 3'b111; cmd.capture = 1'b1; end
          3'd5: cmd.capture = 1'b1;
          3'd6: ;
          default: begin
            cmd.update = !resid_mode;
            cmd.resid = resid_mode;
          end
        endcase
      end
      S_SWEND: ;
      S_ERR: cmd.clr_err = 1'b1;
      S_OUT: ;
      default: ;
    endcase
    cmd.clr_chg = (state == S_SWEND);
  end

  // the own value is fetched in step 0 and latched at the end of step 1
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step <= '0;
      i <= '0;
      sw <= '0;
      n <= '0;
      resid_mode <= 1'b0;
      out_is_err <= 1'b0;
      out_idx <= '0;
      oob_read <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            out_idx <= idx;
            unique case (op)
              OP_READ: begin
                state <= S_READ;
                oob_read <= (32'(idx) >= MAX_ENTRIES);
              end
              OP_RUN: begin
                state <= S_SWEND;
                n <= ncap;
                sw <= '0;
                resid_mode <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_OUT;
          out_is_err <= 1'b0;
        end
        S_ENTRY: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            i <= i + 1'b1;
            if (32'(i) + 1 >= 32'(n)) begin
              if (resid_mode) begin
                state <= S_OUT;
                out_is_err <= 1'b1;
                out_idx <= '0;
              end else begin
                state <= S_SWEND;
                sw <= sw + 1'b1;
              end
            end
          end
        end
        S_SWEND: begin
          // entered at run start (sw 0) and after each sweep
          i <= '0;
          step <= '0;
          if (n == '0) begin
            state <= S_ERR;
          end else if (sw >= sweep_count || (sw != '0 && !sts.changed)) begin
            state <= S_ERR;
          end else begin
            state <= S_ENTRY;
          end
        end
        S_ERR: begin
          resid_mode <= 1'b1;
          i <= CNT_W'(1);
          step <= '0;
          if (n <= CNT_W'(1)) begin
            state <= S_OUT;
            out_is_err <= 1'b1;
            out_idx <= '0;
          end else begin
            state <= S_ENTRY;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/poisson_relaxation_solver_unit.sv =====
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | operation, index, neighbors, rhs, init
// m_axis    | out | m_axis_tvalid/tready    | is_error_report (tuser), pixel, errors
// apb       | in  | psel/penable/pwrite     | entry_count @0, sweep_count @4
//
// load: 1 cycle per transaction while no result waits, written straight into the memories
// read: pixel registered in the read state, valid from the output state; run: each
// sweep takes every entry through row fetch, neighbor fetch, capture and update (one
// shared solution port fetches own value and four neighbors); residual pass from entry 1
// reset (rst, synchronous) inits control and config regs; memories, datapath regs undefined
// input is held off while a result waits in the output register
module poisson_relaxation_solver_unit #(
  parameter int unsigned MAX_ENTRIES = 4096,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], index[13:2], neighbor_a..d[61:14], rhs r,g,b[157:62],
  // init r,g,b[253:158], zero pad to 256
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_index[11:0], pixel r,g,b[35:12], error r,g,b[176:36], pad to 184
  output logic [183:0] m_axis_tdata,
  // is_error_report
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import prs_pkg::*;

  localparam logic [2:0] ADDR_COUNT = 3'd0;
  localparam logic [2:0] ADDR_SWEEP = 3'd4;

  logic [CNT_W-1:0] entry_count;
  logic [SWP_W-1:0] sweep_count;
  cmd_t cmd;
  sts_t sts;
  logic [NCH*8-1:0] pix;
  logic [NCH*ERR_W-1:0] err;
  logic out_is_err, oob_read;
  logic [IDX_W-1:0] out_idx;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_W'(4096);
      sweep_count <= SWP_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_COUNT) entry_count <= pwdata[CNT_W-1:0];
      else if (paddr == ADDR_SWEEP) sweep_count <= pwdata[SWP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_COUNT: prdata = 32'(entry_count);
      ADDR_SWEEP: prdata = 32'(sweep_count);
      default:    prdata = '0;
    endcase
  end

  prs_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(op_t'(s_axis_tdata[1:0])), .idx(s_axis_tdata[13:2]),
    .entry_count, .sweep_count, .sts, .cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_is_err, .out_idx, .oob_read
  );

  prs_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd,
    .ld_nbr(s_axis_tdata[61:14]),
    .ld_rhs(s_axis_tdata[157:62]),
    .ld_init(s_axis_tdata[253:158]),
    .sts, .pix, .err
  );

  // run results carry zero pixels, reads carry zero errors
  assign m_axis_tuser = out_is_err;
  assign m_axis_tdata = {7'd0,
                         out_is_err ? err : {(NCH*ERR_W){1'b0}},
                         (out_is_err || oob_read) ? {(NCH*8){1'b0}} : pix,
                         out_idx};
endmodule
